FILE: src/bbvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbvp_pkg
// Shared types, constants and helpers of the basic block vector profiler.
// ----------------------------------------------------------------------------
package bbvp_pkg;

  localparam int unsigned PcW   = 64;
  localparam int unsigned WordW = 32;
  localparam int unsigned CntW  = 32;
  localparam int unsigned IdW   = 6;
  localparam int unsigned OpW   = 6;
  localparam int unsigned OpLsb = 26;

  localparam logic [WordW-1:0] MarkerWord = 32'h3872_8040; // ibar 0x40
  localparam logic [OpW-1:0]   BrOpLo     = 6'h10;
  localparam logic [OpW-1:0]   BrOpHi     = 6'h1b;
  localparam logic [PcW-1:0]   PcStep     = 64'd4;

  // configuration register indexes
  localparam logic CfgIntervalLength  = 1'b0;
  localparam logic CfgStartAfterMarker = 1'b1;

  typedef struct packed {
    logic [PcW-1:0]   pc;
    logic [WordW-1:0] insn_word;
  } in_beat_t;

  typedef struct packed {
    logic [IdW-1:0]  block_id;
    logic [CntW-1:0] block_count;
    logic            interval_end;
    logic            table_overflow;
  } out_beat_t;

  // request bundle toward the count store
  typedef struct packed {
    logic [IdW-1:0]  rd_addr;
    logic            wr_en;
    logic [IdW-1:0]  wr_addr;
    logic [CntW-1:0] wr_data;
    logic            clr;
  } cnt_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_WR,
    ST_SRCH,
    ST_DUMP_RD,
    ST_DUMP_CHK,
    ST_DUMP_END
  } state_e;

  function automatic logic is_branch(input logic [WordW-1:0] w);
    logic [OpW-1:0] op;
    op = w[OpLsb +: OpW];
    return (op >= BrOpLo) && (op <= BrOpHi);
  endfunction

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/bbvp_count_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbvp_count_store
// Per-id interval count memory, registered read, with a valid bit
// per entry so that reset and end-of-interval clears need no sweep.
// ----------------------------------------------------------------------------
module bbvp_count_store #(
  parameter int unsigned BLOCK_SLOTS = 63
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire bbvp_pkg::cnt_req_t     req_i,
  output logic [bbvp_pkg::CntW-1:0]   rd_data_o
);

  localparam int unsigned Depth = BLOCK_SLOTS + 1;
  localparam int unsigned IdxW  = $clog2(Depth);

  logic [bbvp_pkg::CntW-1:0] mem [Depth];
  logic [Depth-1:0]          vld_q;
  logic [bbvp_pkg::CntW-1:0] rdata_q;
  logic                      rvld_q;

  logic [IdxW-1:0] ra, wa;
  assign ra = req_i.rd_addr[IdxW-1:0];
  assign wa = req_i.wr_addr[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wa] <= req_i.wr_data;
    end
    rdata_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[ra];
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[wa] <= 1'b1;
      end
    end
  end

  // never-written or cleared entries read as zero
  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

FILE: src/basic_block_vector_profiler.sv
// A sequential item is taken in idle; a block start first does the count
//   read-modify-write (ST_CNT_WR) when the ended block has a nonzero id, then searches
//   the stored start pcs in ST_SRCH.
// A dump walks the count memory id by id, a read state then a check state per id, then
//   an end record; it holds while the result side stalls. One item is in flight at a time.
// Reset: asynchronous, active low; count valid bits clear at once, no sweep.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// basic_block_vector_profiler
// Cuts a retired-instruction trace into basic blocks, gives each block start
// pc a permanent id and emits per-interval block counts plus an end record.
// ----------------------------------------------------------------------------
module basic_block_vector_profiler #(
  parameter int unsigned BLOCK_SLOTS = 63
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  bbvp_pkg::in_beat_t     in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output bbvp_pkg::out_beat_t          out_data_o,
  input  wire                          cfg_we_i,
  input  wire                          cfg_idx_i,
  input  wire  [bbvp_pkg::CntW-1:0]    cfg_data_i
);

  localparam int unsigned Depth = BLOCK_SLOTS + 1;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned SrchW = bbvp_pkg::IdW + 1;   // reaches 64
  localparam logic [bbvp_pkg::IdW-1:0] MaxId = bbvp_pkg::IdW'(BLOCK_SLOTS);
  localparam logic [bbvp_pkg::IdW-1:0] OneId = bbvp_pkg::IdW'(1);
  localparam logic [SrchW-1:0] FullLimit = SrchW'(64);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  bbvp_pkg::state_e state_q, state_d;

  logic [bbvp_pkg::CntW-1:0] interval_len_q, interval_len_d;
  logic                      start_mark_q, start_mark_d;

  logic                      started_q, started_d;
  logic                      prev_valid_q, prev_valid_d;
  logic [bbvp_pkg::PcW-1:0]  prev_pc_q, prev_pc_d;
  logic                      prev_br_q, prev_br_d;
  logic [bbvp_pkg::IdW-1:0]  cur_id_q, cur_id_d;
  logic [bbvp_pkg::IdW-1:0]  next_free_q, next_free_d;
  logic [bbvp_pkg::CntW-1:0] run_len_q, run_len_d;
  logic [bbvp_pkg::CntW-1:0] progress_q, progress_d;
  logic                      ovf_q, ovf_d;

  // per-item working registers
  logic [bbvp_pkg::PcW-1:0]  pc_q, pc_d;           // block start pc being looked up
  logic [bbvp_pkg::CntW-1:0] pend_run_q, pend_run_d; // length of the block just ended
  logic                      dump_pend_q, dump_pend_d;
  logic [SrchW-1:0]          srch_id_q, srch_id_d;
  logic                      cmp_vld_q, cmp_vld_d;
  logic [bbvp_pkg::IdW-1:0]  cmp_id_q, cmp_id_d;
  logic [bbvp_pkg::IdW-1:0]  dump_id_q, dump_id_d;

  // result register
  bbvp_pkg::out_beat_t       out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  // --------------------------------------------------------------------------
  // Start pc memory: entry i holds the start pc of block id i
  // --------------------------------------------------------------------------
  logic [bbvp_pkg::PcW-1:0] pc_mem [Depth];
  logic [bbvp_pkg::PcW-1:0] pc_rdata_q;
  logic                     pc_we;
  logic [IdxW-1:0]          pc_waddr, pc_raddr;

  always_ff @(posedge clk_i) begin
    if (pc_we) begin
      pc_mem[pc_waddr] <= pc_q;
    end
    pc_rdata_q <= pc_mem[pc_raddr];
  end

  assign pc_raddr = srch_id_q[IdxW-1:0];
  assign pc_waddr = next_free_q[IdxW-1:0];

  // --------------------------------------------------------------------------
  // Count memory
  // --------------------------------------------------------------------------
  bbvp_pkg::cnt_req_t        cnt_req;
  logic [bbvp_pkg::CntW-1:0] cnt_rdata;

  bbvp_count_store #(
    .BLOCK_SLOTS(BLOCK_SLOTS)
  ) u_count_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (cnt_req),
    .rd_data_o (cnt_rdata)
  );

  // --------------------------------------------------------------------------
  // Decode of the incoming beat
  // --------------------------------------------------------------------------
  logic                      acc;
  logic                      gated;       // still waiting for the marker
  logic                      is_marker;
  logic                      boundary;
  logic [bbvp_pkg::CntW-1:0] prog_inc;
  logic                      dump_now;
  logic                      cnt_upd;     // ended block has a countable id

  assign in_ready_o = (state_q == bbvp_pkg::ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign gated      = start_mark_q && !started_q;
  assign is_marker  = (in_data_i.insn_word == bbvp_pkg::MarkerWord);
  assign boundary   = !prev_valid_q || prev_br_q ||
                      (in_data_i.pc != (prev_pc_q + bbvp_pkg::PcStep));
  assign prog_inc   = bbvp_pkg::sat_add(progress_q, bbvp_pkg::CntW'(1));
  assign dump_now   = (prog_inc >= interval_len_q);
  assign cnt_upd    = (cur_id_q != '0) && (cur_id_q <= MaxId);

  // search: one stored pc read per cycle, compared the cycle after
  logic [SrchW-1:0] srch_limit;
  logic             srch_hit, srch_miss;
  logic             table_full;

  assign srch_limit = (next_free_q == '0) ? FullLimit : {1'b0, next_free_q};
  assign srch_hit   = cmp_vld_q && (pc_rdata_q == pc_q);
  assign srch_miss  = !srch_hit && (srch_id_q >= srch_limit);
  assign table_full = (next_free_q == '0) || (next_free_q > MaxId);

  // dump
  logic slot_free;
  logic cnt_nz;
  logic dump_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign cnt_nz    = (cnt_rdata != '0);
  assign dump_last = (dump_id_q == MaxId);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      bbvp_pkg::ST_IDLE: begin
        if (acc && !gated) begin
          if (boundary) begin
            state_d = cnt_upd ? bbvp_pkg::ST_CNT_WR : bbvp_pkg::ST_SRCH;
          end else if (dump_now) begin
            state_d = bbvp_pkg::ST_DUMP_RD;
          end
        end
      end
      bbvp_pkg::ST_CNT_WR: begin
        state_d = bbvp_pkg::ST_SRCH;
      end
      bbvp_pkg::ST_SRCH: begin
        if (srch_hit || srch_miss) begin
          state_d = dump_pend_q ? bbvp_pkg::ST_DUMP_RD : bbvp_pkg::ST_IDLE;
        end
      end
      bbvp_pkg::ST_DUMP_RD: begin
        state_d = bbvp_pkg::ST_DUMP_CHK;
      end
      bbvp_pkg::ST_DUMP_CHK: begin
        if (!cnt_nz || slot_free) begin
          state_d = dump_last ? bbvp_pkg::ST_DUMP_END : bbvp_pkg::ST_DUMP_RD;
        end
      end
      bbvp_pkg::ST_DUMP_END: begin
        if (slot_free) begin
          state_d = bbvp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bbvp_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    interval_len_d = interval_len_q;
    start_mark_d   = start_mark_q;
    started_d      = started_q;
    prev_valid_d   = prev_valid_q;
    prev_pc_d      = prev_pc_q;
    prev_br_d      = prev_br_q;
    cur_id_d       = cur_id_q;
    next_free_d    = next_free_q;
    run_len_d      = run_len_q;
    progress_d     = progress_q;
    ovf_d          = ovf_q;
    pc_d           = pc_q;
    pend_run_d     = pend_run_q;
    dump_pend_d    = dump_pend_q;
    srch_id_d      = srch_id_q;
    cmp_vld_d      = cmp_vld_q;
    cmp_id_d       = cmp_id_q;
    dump_id_d      = dump_id_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    pc_we          = 1'b0;

    cnt_req         = '0;
    cnt_req.rd_addr = cur_id_q;
    cnt_req.wr_addr = cur_id_q;
    cnt_req.wr_data = bbvp_pkg::sat_add(cnt_rdata, pend_run_q);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        bbvp_pkg::CfgIntervalLength:   interval_len_d = cfg_data_i;
        bbvp_pkg::CfgStartAfterMarker: start_mark_d   = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      bbvp_pkg::ST_IDLE: begin
        // count read for the ended block is issued here, used in ST_CNT_WR
        srch_id_d = SrchW'(1);
        cmp_vld_d = 1'b0;
        dump_id_d = OneId;
        if (acc && (!gated || is_marker)) begin
          started_d    = 1'b1;
          prev_valid_d = 1'b1;
          prev_pc_d    = in_data_i.pc;
          prev_br_d    = bbvp_pkg::is_branch(in_data_i.insn_word);
          progress_d   = prog_inc;
          run_len_d    = bbvp_pkg::sat_add(run_len_q, bbvp_pkg::CntW'(1));
          pc_d         = in_data_i.pc;
          pend_run_d   = run_len_q;
          dump_pend_d  = 1'b0;
          if (!gated) begin
            if (boundary) begin
              run_len_d = bbvp_pkg::CntW'(1);
            end
            if (dump_now) begin
              // open block's partial count is dropped
              progress_d  = '0;
              run_len_d   = '0;
              dump_pend_d = 1'b1;
            end
          end
        end
      end
      bbvp_pkg::ST_CNT_WR: begin
        cnt_req.wr_en = 1'b1;
      end
      bbvp_pkg::ST_SRCH: begin
        if (srch_hit) begin
          cur_id_d = cmp_id_q;
        end else if (srch_miss) begin
          if (table_full) begin
            ovf_d    = 1'b1;
            cur_id_d = '0;
          end else begin
            pc_we       = 1'b1;
            cur_id_d    = next_free_q;
            next_free_d = next_free_q + OneId;   // wraps to 0 past id 63
          end
        end else begin
          cmp_vld_d = 1'b1;
          cmp_id_d  = srch_id_q[bbvp_pkg::IdW-1:0];
          srch_id_d = srch_id_q + SrchW'(1);
        end
      end
      bbvp_pkg::ST_DUMP_RD: begin
        cnt_req.rd_addr = dump_id_q;
      end
      bbvp_pkg::ST_DUMP_CHK: begin
        cnt_req.rd_addr = dump_id_q;   // hold read data while stalled
        if (!cnt_nz || slot_free) begin
          dump_id_d = dump_id_q + OneId;
          if (cnt_nz) begin
            out_valid_d          = 1'b1;
            out_d.block_id       = dump_id_q;
            out_d.block_count    = cnt_rdata;
            out_d.interval_end   = 1'b0;
            out_d.table_overflow = 1'b0;
          end
        end
      end
      bbvp_pkg::ST_DUMP_END: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.block_id       = '0;
          out_d.block_count    = '0;
          out_d.interval_end   = 1'b1;
          out_d.table_overflow = ovf_q;
          ovf_d                = 1'b0;
          cnt_req.clr          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bbvp_pkg::ST_IDLE;
      interval_len_q <= bbvp_pkg::CntW'(1000000);
      start_mark_q   <= 1'b0;
      started_q      <= 1'b0;
      prev_valid_q   <= 1'b0;
      prev_pc_q      <= '0;
      prev_br_q      <= 1'b0;
      cur_id_q       <= '0;
      next_free_q    <= OneId;
      run_len_q      <= '0;
      progress_q     <= '0;
      ovf_q          <= 1'b0;
      dump_pend_q    <= 1'b0;
      srch_id_q      <= '0;
      cmp_vld_q      <= 1'b0;
      dump_id_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      interval_len_q <= interval_len_d;
      start_mark_q   <= start_mark_d;
      started_q      <= started_d;
      prev_valid_q   <= prev_valid_d;
      prev_pc_q      <= prev_pc_d;
      prev_br_q      <= prev_br_d;
      cur_id_q       <= cur_id_d;
      next_free_q    <= next_free_d;
      run_len_q      <= run_len_d;
      progress_q     <= progress_d;
      ovf_q          <= ovf_d;
      dump_pend_q    <= dump_pend_d;
      srch_id_q      <= srch_id_d;
      cmp_vld_q      <= cmp_vld_d;
      dump_id_q      <= dump_id_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q       <= pc_d;
    pend_run_q <= pend_run_d;
    cmp_id_q   <= cmp_id_d;
    out_q      <= out_d;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_end_rec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.interval_end) |->
      (out_data_o.block_id == '0 && out_data_o.block_count == '0))
    else $error("end record carries an id or a count");

  a_cnt_rec_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.interval_end) |->
      (out_data_o.block_id != '0 && out_data_o.block_count != '0 &&
       !out_data_o.table_overflow))
    else $error("malformed count record");

  a_next_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, next_free_q} <= SrchW'(BLOCK_SLOTS + 1)))
    else $error("free id pointer past the table");

  a_cur_id_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_id_q <= MaxId))
    else $error("current block id past the table");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == bbvp_pkg::ST_SRCH) && srch_hit) |->
      (cmp_id_q != '0 && {1'b0, cmp_id_q} < srch_limit))
    else $error("search hit on an unallocated id");
`endif

endmodule
`default_nettype wire
